@@ sv/th_pkg.sv @@
// Shared types and constants for the tabulation hash block.
// Depends on nothing; referred to by scoped names in all files but th_table_ram.
package th_pkg;

	localparam int NUM_TABLES  = 8;
	localparam int HASH_WIDTH  = 32;
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int SEL_W       = $clog2(NUM_TABLES);

	// Operation codes carried by the mode field.
	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_KEY  = 2'd1,
		MODE_BYTE = 2'd2
	} mode_t;

	typedef logic [HASH_WIDTH-1:0] word_t;
	typedef logic [NUM_TABLES-1:0][HASH_WIDTH-1:0] word_vec_t;

	// Control that travels with an item from the read stage into the combine stage.
	typedef struct packed {
		logic             is_key;
		logic             is_byte;
		logic             last;
		logic [SEL_W-1:0] byte_sel;
	} item_ctrl_t;

endpackage

@@ sv/th_table_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Standalone; used once per hash table by the top level.
module th_table_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data register holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/th_combine.sv @@
// Combine stage: XOR tree for keys, string accumulator, and the output register.
// Depends on th_pkg; fed with the registered read data of the eight table RAMs.
module th_combine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  th_pkg::item_ctrl_t ctrl_in,
	input  th_pkg::word_vec_t  rdata,
	input  logic               out_stall,
	output logic               in_stall,
	output logic               out_valid,
	output th_pkg::word_t      hash
);

	logic               valid_s1;
	th_pkg::item_ctrl_t ctrl_s1;
	th_pkg::word_t      acc_q;
	logic               out_valid_q;
	th_pkg::word_t      hash_q;

	logic               out_ready;
	logic               has_result;
	logic               advance;
	th_pkg::word_t      key_hash;
	th_pkg::word_t      acc_next;

	// The stage moves on unless it holds a result that the output register cannot take.
	assign out_ready  = !out_valid_q || !out_stall;
	assign has_result = ctrl_s1.is_key || (ctrl_s1.is_byte && ctrl_s1.last);
	assign advance    = !valid_s1 || !has_result || out_ready;
	assign in_stall   = !advance;

	// XOR of the eight table words for a key.
	always_comb begin
		key_hash = '0;
		for (int i = 0; i < th_pkg::NUM_TABLES; i++) begin
			key_hash = key_hash ^ rdata[i];
		end
	end

	// A string byte folds the word of its selected table into the accumulator.
	assign acc_next = acc_q ^ rdata[ctrl_s1.byte_sel];

	// Stage valid and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1 <= ctrl_in;
		end
	end

	// String accumulator, cleared after the last byte of a string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s1 && ctrl_s1.is_byte && advance) begin
			acc_q <= ctrl_s1.last ? '0 : acc_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s1 && has_result) begin
			hash_q <= ctrl_s1.is_key ? key_hash : acc_next;
		end
	end

	assign out_valid = out_valid_q;
	assign hash      = hash_q;

endmodule

@@ sv/tabulation_hash.sv @@
// Simple tabulation hash over eight tables of 256 words of 32 bits.
// A key or last-byte hash passes the RAM read register, then the output register.
// Throughput: one beat per cycle if not stalled, set by each RAM's one read port.
// Reset clears the stage valid, the output valid and the string accumulator;
// the table RAMs are not cleared and hold nothing defined until loaded.
// Depends on th_pkg, th_table_ram and th_combine.
module tabulation_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [2:0]  table_select,
	input  logic [7:0]  entry_index,
	input  logic [31:0] entry_value,
	input  logic [63:0] key,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] hash
);

	logic               accept;
	logic               is_load;
	logic               is_byte;
	th_pkg::item_ctrl_t ctrl_in;
	th_pkg::word_vec_t  rdata;

	assign accept  = in_valid && !in_stall;
	assign is_load = (mode == th_pkg::MODE_LOAD);
	assign is_byte = (mode == th_pkg::MODE_BYTE);

	assign ctrl_in.is_key   = (mode == th_pkg::MODE_KEY);
	assign ctrl_in.is_byte  = is_byte;
	assign ctrl_in.last     = last_byte;
	assign ctrl_in.byte_sel = key[th_pkg::SEL_W-1:0];

	// One RAM per table; a load writes at acceptance, so the next beat already reads it.
	for (genvar t = 0; t < th_pkg::NUM_TABLES; t++) begin : g_table
		logic [th_pkg::IDX_W-1:0] raddr;

		assign raddr = is_byte ? key[th_pkg::IDX_W-1:0]
		                       : key[t*th_pkg::IDX_W +: th_pkg::IDX_W];

		th_table_ram #(
			.ADDR_W (th_pkg::IDX_W),
			.DATA_W (th_pkg::HASH_WIDTH)
		) u_ram (
			.clk   (clk),
			.we    (accept && is_load && (table_select == t[th_pkg::SEL_W-1:0])),
			.waddr (entry_index),
			.wdata (entry_value[th_pkg::HASH_WIDTH-1:0]),
			.re    (accept),
			.raddr (raddr),
			.rdata (rdata[t])
		);
	end

	th_combine u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.ctrl_in   (ctrl_in),
		.rdata     (rdata),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.hash      (hash)
	);

endmodule

@@ sv/th_checker.sv @@
// Port-level checks for the tabulation hash block, attached by a bind.
// Depends on th_pkg for the operation codes.
module th_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  mode,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] hash
);

	logic res_beat;

	// An accepted beat that must produce a hash.
	assign res_beat = in_valid && !in_stall &&
		((mode == th_pkg::MODE_KEY) || ((mode == th_pkg::MODE_BYTE) && last_byte));

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hash))
		else $error("result beat dropped or changed while stalled");

	// The input side only stalls when the output side is backed up.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with the output free");

	// A result rising on an idle output traces back to an accepted hashing beat.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(res_beat, 2))
		else $error("result beat without a matching input beat");

	// Nothing is offered right after reset.
	a_reset_empty: assert property (@(posedge clk)
		$past(!arst_n) |-> !out_valid)
		else $error("result beat offered out of reset");

endmodule

bind tabulation_hash th_checker u_th_checker (.*);
